### hw/rtl/queue_with_middle_insert_defines.svh
// Assertion macros shared by the queue with middle insert RTL.
`ifndef QUEUE_WITH_MIDDLE_INSERT_DEFINES_SVH
`define QUEUE_WITH_MIDDLE_INSERT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QMI_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("queue assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define QMI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("queue assertion failed");

`endif

### hw/rtl/qmi_pkg.sv
// Package with the types and constants of the queue with middle insert.
`default_nettype none

package qmi_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned DataW    = 32;
  localparam int unsigned OccW     = 7;

  typedef enum logic [1:0] {
    OP_PUSH_TAIL = 2'd0,
    OP_PUSH_MID  = 2'd1,
    OP_POP       = 2'd2,
    OP_NONE      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // What a cell loads at the next clock edge.
  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_LOAD,
    SEL_PREV,
    SEL_NEXT
  } cell_sel_e;

  typedef struct packed {
    cell_sel_e sel;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/qmi_cell.sv
// One storage cell of the queue chain: holds a word, loads a new one, or takes it from a neighbor.
`default_nettype none

module qmi_cell (
  input  wire logic                      clk_i,
  input  wire qmi_pkg::cell_ctrl_t       ctrl_i,
  input  wire logic [qmi_pkg::DataW-1:0] load_i,
  input  wire logic [qmi_pkg::DataW-1:0] prev_i,
  input  wire logic [qmi_pkg::DataW-1:0] next_i,
  output logic      [qmi_pkg::DataW-1:0] data_o
);
  import qmi_pkg::*;

  logic [DataW-1:0] data_d, data_q;

  always_comb begin
    unique case (ctrl_i.sel)
      SEL_LOAD: data_d = load_i;
      SEL_PREV: data_d = prev_i;
      SEL_NEXT: data_d = next_i;
      default:  data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

### hw/rtl/queue_with_middle_insert.sv
// Top level of the queue with middle insert: control and the chain of cells.
//
// A bounded queue of signed 32-bit words built as a row of cells. Cell 0 is
// the head. Each operation enters with start while busy is low; busy is
// always low, so one operation is taken every clock cycle.
// Operation codes: push at tail, push at middle (ceil(n/2) words stay ahead
// of the new one), pop from head. The unused code changes nothing.
// Every operation gives one result in the cycle after it is taken: result_valid_o
// is high for that single cycle with popped_value_o, status_o and occupancy_o.
// Throughput is one operation per cycle, set by the cell chain: a middle
// insert shifts every cell behind the insert point by one place in parallel,
// and a pop shifts the whole row toward the head.
// A pop on an empty queue reports the empty status; a push on a full queue
// reports the full status; in both cases the contents stay as they are.
// Reset empties the queue and clears the result strobe; the cell words are
// not reset and are never read before they are written.
// The receiver cannot stall: each result must be taken in its one cycle.
`default_nettype none
`include "queue_with_middle_insert_defines.svh"

module queue_with_middle_insert (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       operation_i,
  input  wire logic signed [qmi_pkg::DataW-1:0] push_value_i,
  output logic                                  result_valid_o,
  output logic signed [qmi_pkg::DataW-1:0]      popped_value_o,
  output logic [1:0]                            status_o,
  output logic [qmi_pkg::OccW-1:0]              occupancy_o
);
  import qmi_pkg::*;

  logic                      accept;
  logic                      is_push, is_pop, full, empty;
  logic                      push_ok, pop_ok;
  logic [CntW-1:0]           pos;
  logic [CntW-1:0]           count_d, count_q;
  logic                      valid_q;
  logic [DataW-1:0]          popped_d, popped_q;
  status_e                   status_d, status_q;
  logic [Capacity-1:0][DataW-1:0] cell_data;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign is_push = (operation_i == OP_PUSH_TAIL) || (operation_i == OP_PUSH_MID);
  assign is_pop  = (operation_i == OP_POP);
  assign full    = (count_q == CntW'(Capacity));
  assign empty   = (count_q == '0);
  assign push_ok = accept && is_push && !full;
  assign pop_ok  = accept && is_pop && !empty;

  // Insert position: the tail, or ceil(n/2) for a middle insert.
  always_comb begin
    if (operation_i == OP_PUSH_TAIL) begin
      pos = count_q;
    end else begin
      pos = (count_q >> 1) + CntW'(count_q[0]);
    end
  end

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic [DataW-1:0] prev_w, next_w;
    cell_ctrl_t       ctrl_w;

    always_comb begin
      priority if (push_ok && CntW'(i) == pos) begin
        ctrl_w.sel = SEL_LOAD;
      end else if (push_ok && CntW'(i) > pos) begin
        ctrl_w.sel = SEL_PREV;
      end else if (pop_ok) begin
        ctrl_w.sel = SEL_NEXT;
      end else begin
        ctrl_w.sel = SEL_HOLD;
      end
    end

    if (i == 0) begin : g_head
      assign prev_w = '0;
    end else begin : g_body
      assign prev_w = cell_data[i-1];
    end

    if (i == Capacity - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_inner
      assign next_w = cell_data[i+1];
    end

    qmi_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl_w),
      .load_i (push_value_i),
      .prev_i (prev_w),
      .next_i (next_w),
      .data_o (cell_data[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    popped_d = '0;
    status_d = ST_DONE;
    if (accept) begin
      if (is_push) begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end else if (is_pop) begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          popped_d = cell_data[0];
          count_d  = count_q - CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    popped_q <= popped_d;
    status_q <= status_d;
  end

  assign result_valid_o = valid_q;
  assign popped_value_o = popped_q;
  assign status_o       = status_q;
  assign occupancy_o    = OccW'(count_q);

  `QMI_ASSERT_NEXT(a_result_follows_accept, clk_i, rst_ni, accept, valid_q)
  `QMI_ASSERT_NEXT(a_no_spurious_result, clk_i, rst_ni, !accept, !valid_q)
  `QMI_ASSERT_SAME(a_count_bounded, clk_i, rst_ni, 1'b1, count_q <= CntW'(Capacity))
  `QMI_ASSERT_NEXT(a_pop_decrements, clk_i, rst_ni, pop_ok, count_q == $past(count_q) - CntW'(1))
  `QMI_ASSERT_NEXT(a_full_rejects, clk_i, rst_ni, accept && is_push && full, (status_q == ST_FULL) && $stable(count_q))

endmodule

`default_nettype wire

### test/tb_queue_with_middle_insert.sv
// Self-checking testbench for the queue with middle insert.
`default_nettype none

module tb_queue_with_middle_insert;
  timeunit 1ns;
  timeprecision 1ps;

  import qmi_pkg::*;

  typedef struct packed {
    logic signed [DataW-1:0] popped;
    status_e                 status;
    logic [OccW-1:0]         occupancy;
  } queue_result_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [1:0]              operation_i;
  logic signed [DataW-1:0] push_value_i;
  logic                    result_valid_o;
  logic signed [DataW-1:0] popped_value_o;
  logic [1:0]              status_o;
  logic [OccW-1:0]         occupancy_o;

  // Words the queue should hold, head first, and results still to come.
  logic signed [DataW-1:0] queue_contents[$];
  queue_result_t           pending_results[$];

  int unsigned mismatch_count;
  int unsigned op_count[4];
  int unsigned full_rejects;
  int unsigned empty_pops;
  int unsigned peak_occupancy;
  bit          no_idle;

  queue_with_middle_insert DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .push_value_i   (push_value_i),
    .result_valid_o (result_valid_o),
    .popped_value_o (popped_value_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("queue_with_middle_insert: mismatch");
    $finish;
  end

  // Applies one operation to the queue image and records the result it owes.
  function automatic void predict_queue_step(input logic [1:0] op,
                                             input logic signed [DataW-1:0] value);
    queue_result_t res;
    int unsigned   n;
    int unsigned   pos;
    res        = '0;
    res.status = ST_DONE;
    n          = queue_contents.size();
    case (op)
      OP_PUSH_TAIL, OP_PUSH_MID: begin
        if (n >= Capacity) begin
          res.status = ST_FULL;
          full_rejects++;
        end else begin
          pos = (op == OP_PUSH_TAIL) ? n : (n + 1) / 2;
          queue_contents.insert(pos, value);
        end
      end
      OP_POP: begin
        if (n == 0) begin
          res.status = ST_EMPTY;
          empty_pops++;
        end else begin
          res.popped = queue_contents.pop_front();
        end
      end
      default: ;
    endcase
    res.occupancy = OccW'(queue_contents.size());
    if (queue_contents.size() > peak_occupancy) peak_occupancy = queue_contents.size();
    op_count[op]++;
    pending_results = {pending_results, res};
  endfunction

  // Compare every result word with the oldest pending expectation.
  always @(posedge clk_i) begin : check_results
    queue_result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        $error("result word arrived with no operation pending");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (popped_value_o !== want.popped) begin
          $error("popped_value: expected %0d, got %0d", want.popped, popped_value_o);
          mismatch_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatch_count++;
        end
        if (occupancy_o !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy_o);
          mismatch_count++;
        end
      end
    end
  end

  // Called just after a falling edge; returns just after the next falling edge
  // once the word has been taken.
  task automatic send_word(input logic [1:0] op, input logic signed [DataW-1:0] value);
    start        <= 1'b1;
    operation_i  <= op;
    push_value_i <= value;
    do @(posedge clk_i); while (busy);
    predict_queue_step(op, value);
    @(negedge clk_i);
  endtask

  task automatic idle_for(input int unsigned cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic int unsigned next_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic logic signed [DataW-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return $signed(32'($urandom_range(0, 15))) - 32'sd8;
      default: return $signed($urandom);
    endcase
  endfunction

  task automatic send_with_gap(input logic [1:0] op, input logic signed [DataW-1:0] value);
    send_word(op, value);
    idle_for(next_gap());
  endtask

  // Empty queue: pop and the unused code must leave it empty.
  task automatic test_empty_queue();
    send_with_gap(OP_POP, 32'sd0);
    send_with_gap(OP_NONE, 32'sh7fff_ffff);
    send_with_gap(OP_POP, 32'sh8000_0000);
  endtask

  // Middle inserts on even and odd counts, extremes of the value, then drain.
  task automatic test_insert_positions();
    send_with_gap(OP_PUSH_MID, 32'sh8000_0000);
    send_with_gap(OP_PUSH_MID, 32'sh7fff_ffff);
    send_with_gap(OP_PUSH_TAIL, -32'sd1);
    send_with_gap(OP_PUSH_MID, 32'sd0);
    send_with_gap(OP_PUSH_MID, 32'sh5555_5555);
    send_with_gap(OP_PUSH_TAIL, 32'shAAAA_AAAA);
    send_with_gap(OP_NONE, 32'sd12345);
    send_with_gap(OP_PUSH_MID, 32'sd1);
    repeat (8) send_with_gap(OP_POP, 32'sh7fff_ffff);
  endtask

  // Fill to capacity, hit the full case with both pushes, then drain past empty.
  task automatic test_fill_and_drain();
    while (queue_contents.size() < Capacity)
      send_with_gap($urandom_range(0, 1) ? OP_PUSH_MID : OP_PUSH_TAIL, random_word());
    send_with_gap(OP_PUSH_TAIL, random_word());
    send_with_gap(OP_PUSH_MID, random_word());
    send_with_gap(OP_NONE, random_word());
    send_with_gap(OP_POP, random_word());
    send_with_gap(OP_PUSH_MID, random_word());
    send_with_gap(OP_PUSH_MID, random_word());
    while (queue_contents.size() > 0) send_with_gap(OP_POP, random_word());
    send_with_gap(OP_POP, random_word());
  endtask

  // Random walk between empty and full, with bursts and full drains mixed in.
  task automatic test_random_walk(input int unsigned items);
    bit          growing;
    int unsigned r;
    logic [1:0]  op;
    growing = 1'b1;
    for (int unsigned i = 0; i < items; i++) begin
      if (i % 64 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if (queue_contents.size() >= Capacity && $urandom_range(0, 3) == 0) growing = 1'b0;
      if (queue_contents.size() == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
      r = $urandom_range(0, 99);
      if (growing) op = (r < 40) ? OP_PUSH_TAIL : (r < 75) ? OP_PUSH_MID :
                        (r < 95) ? OP_POP : OP_NONE;
      else         op = (r < 15) ? OP_PUSH_TAIL : (r < 30) ? OP_PUSH_MID :
                        (r < 95) ? OP_POP : OP_NONE;
      send_word(op, random_word());
      if (i == items / 2 || $urandom_range(0, 99) < 3) wait_for_drain();
      else idle_for(next_gap());
    end
    no_idle = 1'b0;
  endtask

  initial begin : run_tests
    int unsigned settle;
    rst_ni       = 1'b0;
    start        = 1'b0;
    operation_i  = OP_PUSH_TAIL;
    push_value_i = '0;
    no_idle      = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_queue();
    test_insert_positions();
    test_fill_and_drain();
    test_random_walk(400);

    start <= 1'b0;
    settle = 0;
    while (pending_results.size() != 0 && settle < 1000) begin
      @(negedge clk_i);
      settle++;
    end
    repeat (4) @(negedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatch_count++;
    end

    $display("Sent %0d tail pushes, %0d middle pushes, %0d pops, %0d unused codes.",
             op_count[OP_PUSH_TAIL], op_count[OP_PUSH_MID], op_count[OP_POP],
             op_count[OP_NONE]);
    $display("Saw %0d pushes on a full queue, %0d pops on an empty one, peak depth %0d.",
             full_rejects, empty_pops, peak_occupancy);
    if (mismatch_count == 0) begin
      $display("queue_with_middle_insert: match");
    end else begin
      $display("queue_with_middle_insert: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
